>>> hw/rtl/ps2mt_pkg.sv
// ps2mt_pkg: shared types and constants of the mouse packet tracker
// used by ps2mt_framer, ps2mt_cursor and ps2_mouse_packet_tracker
`default_nettype none

package ps2mt_pkg;

    localparam int CFG_W = 13;
    localparam int IDX_W = 8;
    localparam int CFG_DATA_W = 16;
    localparam int BYTE_W = 8;

    localparam logic [IDX_W-1:0] REG_SCREEN_WIDTH  = 8'd0;
    localparam logic [IDX_W-1:0] REG_SCREEN_HEIGHT = 8'd1;

    localparam logic [CFG_W-1:0] RESET_SCREEN_WIDTH  = 13'd1024;
    localparam logic [CFG_W-1:0] RESET_SCREEN_HEIGHT = 13'd768;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DX     = 2'd1,
        PH_DY     = 2'd2
    } t_phase;

    // one complete packet as seen on the byte that closes it
    typedef struct packed {
        logic              left;
        logic              right;
        logic              middle;
        logic signed [7:0] dx;
        logic signed [7:0] dy;
    } t_packet;

endpackage

`default_nettype wire

>>> hw/rtl/ps2mt_framer.sv
// ps2mt_framer: groups mouse bytes into header, x delta and y delta
// depends on ps2mt_pkg
`default_nettype none

module ps2mt_framer
    import ps2mt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_advance,
    input  wire logic [BYTE_W-1:0] i_byte,
    output t_packet                o_packet,
    output logic                   o_done
);

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_header, n_header;
    logic [BYTE_W-1:0] r_dx, n_dx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_header <= '0;
            r_dx     <= '0;
        end else begin
            r_phase  <= n_phase;
            r_header <= n_header;
            r_dx     <= n_dx;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_header = r_header;
        n_dx     = r_dx;
        o_done   = 1'b0;
        unique case (r_phase)
            PH_DX: begin
                if (i_advance) begin
                    n_dx    = i_byte;
                    n_phase = PH_DY;
                end
            end
            PH_DY: begin
                o_done = 1'b1;
                if (i_advance) begin
                    n_phase = PH_HEADER;
                end
            end
            default: begin
                // header, and the unused phase code falls back to it
                if (i_advance) begin
                    n_header = i_byte;
                    n_phase  = PH_DX;
                end
            end
        endcase
    end

    assign o_packet.left   = r_header[0];
    assign o_packet.right  = r_header[1];
    assign o_packet.middle = r_header[2];
    assign o_packet.dx     = $signed(r_dx);
    assign o_packet.dy     = $signed(i_byte);

endmodule

`default_nettype wire

>>> hw/rtl/ps2mt_cursor.sv
// ps2mt_cursor: cursor position and button registers, add and clamp per packet
// depends on ps2mt_pkg
`default_nettype none

module ps2mt_cursor
    import ps2mt_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_step,
    input  wire t_packet               i_packet,
    input  wire logic [COORD_BITS-1:0] i_max_x,
    input  wire logic [COORD_BITS-1:0] i_max_y,
    output logic      [COORD_BITS-1:0] o_pos_x,
    output logic      [COORD_BITS-1:0] o_pos_y,
    output logic      [2:0]            o_buttons
);

    localparam int SW = COORD_BITS + 2;

    logic [COORD_BITS-1:0] r_x, n_x;
    logic [COORD_BITS-1:0] r_y, n_y;
    logic [2:0]            r_buttons, n_buttons;
    logic signed [SW-1:0]  w_sum_x, w_sum_y;

    function automatic logic [COORD_BITS-1:0] f_clamp(
        input logic signed [SW-1:0]  v,
        input logic [COORD_BITS-1:0] mx
    );
        logic [COORD_BITS-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > $signed({2'b00, mx})) begin
            res = mx;
        end else begin
            res = v[COORD_BITS-1:0];
        end
        return res;
    endfunction

    // y grows downward, so the mouse y delta is subtracted
    assign w_sum_x = $signed({2'b00, r_x}) + SW'(i_packet.dx);
    assign w_sum_y = $signed({2'b00, r_y}) - SW'(i_packet.dy);

    always_comb begin
        n_x       = r_x;
        n_y       = r_y;
        n_buttons = r_buttons;
        if (i_step) begin
            n_x       = f_clamp(w_sum_x, i_max_x);
            n_y       = f_clamp(w_sum_y, i_max_y);
            n_buttons = {i_packet.middle, i_packet.right, i_packet.left};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x       <= '0;
            r_y       <= '0;
            r_buttons <= '0;
        end else begin
            r_x       <= n_x;
            r_y       <= n_y;
            r_buttons <= n_buttons;
        end
    end

    assign o_pos_x   = r_x;
    assign o_pos_y   = r_y;
    assign o_buttons = r_buttons;

endmodule

`default_nettype wire

>>> hw/rtl/ps2_mouse_packet_tracker.sv
// ps2_mouse_packet_tracker: top level, byte input register, config, result handshake
// depends on ps2mt_pkg, ps2mt_framer, ps2mt_cursor
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+----------------------------------
//  s stream | in  | i_s_tvalid/o_s_tready  | data_byte
//  m stream | out | o_m_tvalid/i_m_tready  | pos_x, pos_y; tuser: buttons
//  cfg      | in  | i_cfg_valid/o_cfg_ready| register index, write data
//
// one byte per cycle unless a closing byte waits on an untaken result: each
// byte passes the input register, then the packet-closing byte adds and clamps
// straight into the cursor registers, which are the result register. the valid
// of a result is set with those registers, on the step of its closing byte.
// reset is synchronous, clears phase, cursor and valids, reloads default config.
// a stalled result holds only the closing byte; header and x bytes keep flowing.
`default_nettype none

module ps2_mouse_packet_tracker
    import ps2mt_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [BYTE_W-1:0]     i_s_tdata,   // [7:0] data_byte
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [((2 * COORD_BITS + 7) / 8) * 8 - 1:0] o_m_tdata,  // pos_x, pos_y, zero fill
    output logic [2:0]                 o_m_tuser,   // left, right, middle
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [IDX_W-1:0]      i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int OUT_W = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int LW = 17;

    function automatic logic [COORD_BITS-1:0] f_max(input logic [CFG_W-1:0] res);
        logic [LW-1:0]         wide;
        logic [LW-1:0]         less;
        logic [COORD_BITS-1:0] mx;
        wide = LW'(res);
        less = wide - LW'(1);
        if (res == '0) begin
            mx = '0;
        end else if (wide > (LW'(1) << COORD_BITS)) begin
            mx = '1;
        end else begin
            mx = less[COORD_BITS-1:0];
        end
        return mx;
    endfunction

    logic [COORD_BITS-1:0] r_max_x, r_max_y;
    logic                  r_in_valid;
    logic [BYTE_W-1:0]     r_in_byte;
    logic                  r_out_valid, n_out_valid;
    logic                  w_advance, w_step, w_done, w_take;
    t_packet               w_packet;
    logic [COORD_BITS-1:0] w_pos_x, w_pos_y;
    logic [2:0]            w_buttons;

    // config: clamp limit kept as resolution minus one, zero for a zero resolution, saturated at the coordinate range
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_x <= f_max(RESET_SCREEN_WIDTH);
            r_max_y <= f_max(RESET_SCREEN_HEIGHT);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_SCREEN_WIDTH) begin
                r_max_x <= f_max(i_cfg_data[CFG_W-1:0]);
            end
            if (i_cfg_index == REG_SCREEN_HEIGHT) begin
                r_max_y <= f_max(i_cfg_data[CFG_W-1:0]);
            end
        end
    end

    // input register moves on unless its byte closes a packet and the result waits
    assign w_take     = r_out_valid && i_m_tready;
    assign w_advance  = r_in_valid && (!w_done || !r_out_valid || i_m_tready);
    assign w_step     = w_advance && w_done;
    assign o_s_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_step) begin
            n_out_valid = 1'b1;
        end else if (w_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    ps2mt_framer u_framer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_byte    (r_in_byte),
        .o_packet  (w_packet),
        .o_done    (w_done)
    );

    ps2mt_cursor #(
        .COORD_BITS (COORD_BITS)
    ) u_cursor (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_packet  (w_packet),
        .i_max_x   (r_max_x),
        .i_max_y   (r_max_y),
        .o_pos_x   (w_pos_x),
        .o_pos_y   (w_pos_y),
        .o_buttons (w_buttons)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_W'({w_pos_y, w_pos_x});
    assign o_m_tuser  = w_buttons;

    a_step_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> o_m_tvalid)
        else $error("closing byte did not give a result");

    a_held_byte_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("stalled byte lost from input register");

    a_clamped_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> (w_pos_x <= $past(r_max_x) && w_pos_y <= $past(r_max_y)))
        else $error("cursor beyond clamp limit");

endmodule

`default_nettype wire

>>> tb/tb.sv
// tb: self-checking testbench for ps2_mouse_packet_tracker, streams mouse bytes with random gaps
// and checks every cursor report against an in-bench packet tracker; depends on ps2mt_pkg
`default_nettype none

module tb
    import ps2mt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS  = 12;
    localparam int OUT_W       = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 5000;
    localparam int IDLE_WAIT   = 8;
    localparam int RANDOM_BYTES = 440;

    // register index that decodes to nothing
    localparam logic [IDX_W-1:0] REG_UNUSED = 8'd2;

    typedef struct {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  left;
        logic                  right;
        logic                  middle;
    } t_cursor_report;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [BYTE_W-1:0]     i_s_tdata = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_W-1:0]      o_m_tdata;
    logic [2:0]            o_m_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [IDX_W-1:0]      i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // in-bench copy of the tracker state
    logic [CFG_W-1:0]      trk_width = RESET_SCREEN_WIDTH;
    logic [CFG_W-1:0]      trk_height = RESET_SCREEN_HEIGHT;
    t_phase                trk_phase = PH_HEADER;
    logic [7:0]            trk_header = '0;
    logic [7:0]            trk_dx = '0;
    logic [COORD_BITS-1:0] trk_x = '0;
    logic [COORD_BITS-1:0] trk_y = '0;

    t_cursor_report pending_reports[$];
    int             error_count = 0;
    int             stall_cycles = 0;
    bit             tx_fast = 1'b0;
    bit             rx_fast = 1'b0;
    bit             hold_req = 1'b0;

    ps2_mouse_packet_tracker #(
        .COORD_BITS(COORD_BITS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [COORD_BITS-1:0] clamp_to_screen(input int v,
                                                               input logic [CFG_W-1:0] res);
        int lim;
        lim = int'(res);
        if (lim == 0) lim = 1;
        if (lim > (1 << COORD_BITS)) lim = 1 << COORD_BITS;
        if (v < 0) return '0;
        if (v >= lim) return COORD_BITS'(lim - 1);
        return COORD_BITS'(v);
    endfunction

    function automatic void track_byte(input logic [7:0] b);
        t_cursor_report rep;
        int nx;
        int ny;
        case (trk_phase)
            PH_DX: begin
                trk_dx = b;
                trk_phase = PH_DY;
            end
            PH_DY: begin
                trk_phase = PH_HEADER;
                nx = int'(trk_x) + int'($signed(trk_dx));
                ny = int'(trk_y) - int'($signed(b));
                trk_x = clamp_to_screen(nx, trk_width);
                trk_y = clamp_to_screen(ny, trk_height);
                rep.x = trk_x;
                rep.y = trk_y;
                rep.left = trk_header[0];
                rep.right = trk_header[1];
                rep.middle = trk_header[2];
                pending_reports.push_back(rep);
            end
            default: begin
                trk_header = b;
                trk_phase = PH_DX;
            end
        endcase
    endfunction

    // follow accepted bytes and register writes
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) track_byte(i_s_tdata);
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_SCREEN_WIDTH) trk_width = i_cfg_data[CFG_W-1:0];
            else if (i_cfg_index == REG_SCREEN_HEIGHT) trk_height = i_cfg_data[CFG_W-1:0];
        end
    end

    // report checker
    always @(posedge i_clk) begin
        t_cursor_report want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_reports.size() == 0) begin
                $error("report with nothing expected: tdata=%h tuser=%b", o_m_tdata, o_m_tuser);
                error_count++;
            end else begin
                want = pending_reports.pop_front();
                if (o_m_tdata[COORD_BITS-1:0] !== want.x) begin
                    $error("pos_x: expected %0d, actual %0d", want.x, o_m_tdata[COORD_BITS-1:0]);
                    error_count++;
                end
                if (o_m_tdata[2*COORD_BITS-1:COORD_BITS] !== want.y) begin
                    $error("pos_y: expected %0d, actual %0d", want.y,
                           o_m_tdata[2*COORD_BITS-1:COORD_BITS]);
                    error_count++;
                end
                if (o_m_tuser[0] !== want.left) begin
                    $error("left_pressed: expected %b, actual %b", want.left, o_m_tuser[0]);
                    error_count++;
                end
                if (o_m_tuser[1] !== want.right) begin
                    $error("right_pressed: expected %b, actual %b", want.right, o_m_tuser[1]);
                    error_count++;
                end
                if (o_m_tuser[2] !== want.middle) begin
                    $error("middle_pressed: expected %b, actual %b", want.middle, o_m_tuser[2]);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles where nothing moves
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap(input bit fast);
        int r;
        if (fast) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // result side ready, with one long hold-off on request
    initial begin : rx_ready_gen
        int n;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                n = pick_gap(rx_fast);
                if (n > 0) begin
                    i_m_tready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
                i_m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap(tx_fast);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= b;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic send_packet(input logic [7:0] hdr, input logic [7:0] dx,
                               input logic [7:0] dy);
        send_byte(hdr);
        send_byte(dx);
        send_byte(dy);
    endtask

    // all reports in, then let any header or x byte settle
    task automatic wait_block_idle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_reports.size() > 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // upper data bits are don't-care, so fill them at random
    task automatic set_screen(input int w, input int h);
        write_register(REG_SCREEN_WIDTH, {3'($urandom_range(0, 7)), CFG_W'(w)});
        write_register(REG_SCREEN_HEIGHT, {3'($urandom_range(0, 7)), CFG_W'(h)});
    endtask

    function automatic logic [7:0] pick_delta();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return 8'($urandom_range(0, 255));
        if (r < 7) return 8'($signed($urandom_range(0, 16)) - 8);
        case ($urandom_range(0, 4))
            0: return 8'h7F;
            1: return 8'h80;
            2: return 8'h01;
            3: return 8'hFF;
            default: return 8'h00;
        endcase
    endfunction

    task automatic test_directed();
        send_packet(8'h07, 8'h7F, 8'h80);   // all buttons, largest deltas
        send_packet(8'h00, 8'h80, 8'h7F);   // x goes below zero
        send_packet(8'hF8, 8'hFF, 8'h01);   // ignored header bits set
        send_packet(8'h01, 8'h00, 8'h00);
        send_packet(8'h02, 8'h01, 8'hFF);
        send_packet(8'h04, 8'h7F, 8'h80);
        send_packet(8'hFF, 8'h55, 8'hAA);
        send_byte(8'h03);                   // stray byte shifts the framing
        send_packet(8'h10, 8'h20, 8'h40);
        wait_block_idle();
    endtask

    task automatic test_resolution_extremes();
        // largest range: walk both coordinates to the top
        set_screen(4096, 8191);
        repeat (34) send_packet(8'($urandom_range(0, 255)), 8'h7F, 8'h80);
        wait_block_idle();
        // one pixel: the next packet clamps the cursor from the far corner
        set_screen(1, 1);
        send_packet(8'h05, 8'h7F, 8'h80);
        send_packet(8'h02, 8'h80, 8'h7F);
        wait_block_idle();
        // zero resolution acts as one
        set_screen(0, 0);
        send_packet(8'h07, 8'h10, 8'hF0);
        send_packet(8'h00, pick_delta(), pick_delta());
        wait_block_idle();
        write_register(REG_UNUSED, 16'($urandom_range(0, 65535)));
        set_screen(8191, 4097);
        repeat (34) send_packet(8'($urandom_range(0, 255)), 8'h7F, 8'h80);
        wait_block_idle();
        // shrink while the cursor sits outside, then head back toward zero
        set_screen(300, 200);
        send_packet(8'h01, 8'h00, 8'h00);
        repeat (4) send_packet(8'h06, 8'h80, 8'h7F);
        wait_block_idle();
        set_screen(int'(RESET_SCREEN_WIDTH), int'(RESET_SCREEN_HEIGHT));
    endtask

    task automatic test_output_backpressure();
        hold_req = 1'b1;
        tx_fast = 1'b1;
        repeat (40) send_packet(8'($urandom_range(0, 255)), pick_delta(), pick_delta());
        tx_fast = 1'b0;
        wait_block_idle();
    endtask

    task automatic test_random_stream();
        int sent;
        int r;
        int w;
        int h;
        for (int chunk = 0; chunk < 4; chunk++) begin
            tx_fast = (chunk == 1);
            rx_fast = (chunk == 2);
            sent = 0;
            while (sent < RANDOM_BYTES / 4) begin
                if ($urandom_range(0, 99) < 5) begin
                    send_byte(8'($urandom_range(0, 255)));
                    sent += 1;
                end else begin
                    send_packet(8'($urandom_range(0, 255)), pick_delta(), pick_delta());
                    sent += 3;
                end
            end
            tx_fast = 1'b0;
            rx_fast = 1'b0;
            wait_block_idle();
            r = $urandom_range(0, 9);
            if (r == 0) w = $urandom_range(0, 1);
            else if (r == 1) w = $urandom_range(4096, 8191);
            else w = $urandom_range(1, 4096);
            r = $urandom_range(0, 9);
            if (r == 0) h = $urandom_range(0, 1);
            else if (r == 1) h = $urandom_range(4096, 8191);
            else h = $urandom_range(1, 4096);
            set_screen(w, h);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_resolution_extremes();
        test_output_backpressure();
        test_random_stream();
        wait_block_idle();
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
hw/rtl/ps2mt_pkg.sv
hw/rtl/ps2mt_framer.sv
hw/rtl/ps2mt_cursor.sv
hw/rtl/ps2_mouse_packet_tracker.sv
tb/tb.sv
